@@ hdl/gmrf_pkg.sv @@
// ----------------------------------------------------------------------------
// gmrf_pkg
// Shared types and constants for the grouped median RGB filter: the register
// map of the configuration port and the column mask used by the median unit.
// ----------------------------------------------------------------------------
package gmrf_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 16;

  // Row counter runs one row past the frame height while the frame drains.
  localparam int ROW_W = HEIGHT_REG_W + 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Which window columns fall outside the frame and read as zero.
  typedef struct packed {
    logic left_zero;
    logic right_zero;
  } col_mask_t;

endpackage

@@ hdl/gmrf_ram.sv @@
// ----------------------------------------------------------------------------
// gmrf_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module gmrf_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read at the address being written returns old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/gmrf_pmed.sv @@
// ----------------------------------------------------------------------------
// gmrf_pmed
// Pseudo-median of one color channel over a 3x3 window: the median of the
// medians of three fixed groups of three window positions.
// ----------------------------------------------------------------------------
module gmrf_pmed #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic [2:0][CHANNEL_BITS-1:0] left_col_i,
  input  logic [2:0][CHANNEL_BITS-1:0] center_col_i,
  input  logic [2:0][CHANNEL_BITS-1:0] right_col_i,
  input  gmrf_pkg::col_mask_t          mask_i,
  output logic [CHANNEL_BITS-1:0]      med_o
);

  logic [2:0][CHANNEL_BITS-1:0] left_col;
  logic [2:0][CHANNEL_BITS-1:0] right_col;
  logic [CHANNEL_BITS-1:0]      group_a;
  logic [CHANNEL_BITS-1:0]      group_b;
  logic [CHANNEL_BITS-1:0]      group_c;

  function automatic logic [CHANNEL_BITS-1:0] med3(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b,
    input logic [CHANNEL_BITS-1:0] c
  );
    logic [CHANNEL_BITS-1:0] lo;
    logic [CHANNEL_BITS-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      med3 = lo;
    end else if (c >= hi) begin
      med3 = hi;
    end else begin
      med3 = c;
    end
  endfunction

  // Columns outside the frame read as zero padding.
  assign left_col  = mask_i.left_zero  ? '0 : left_col_i;
  assign right_col = mask_i.right_zero ? '0 : right_col_i;

  // Groups in row-major window positions: {0,5,6}, {2,3,8} and {1,4,7}.
  assign group_a = med3(left_col[0], right_col[1], left_col[2]);
  assign group_b = med3(right_col[0], left_col[1], right_col[2]);
  assign group_c = med3(center_col_i[0], center_col_i[1], center_col_i[2]);

  assign med_o = med3(group_a, group_b, group_c);

endmodule

@@ hdl/grouped_median_rgb_filter_top.sv @@
// ----------------------------------------------------------------------------
// grouped_median_rgb_filter_top
// Streaming 3x3 pseudo-median filter for RGB pixels in raster order, with
// two line memories, a sliding window of whole RGB pixels and zero padding.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake                  Payload
//   -------  -------------------------  ------------------------------------
//   input    in_valid_i / in_stall_o    red/green/blue_in_i, is_flush_i
//   output   out_valid_o / out_stall_i  red/green/blue_out_o, frame_last_o
//   config   cfg_we_i                   cfg_index_i, cfg_data_i
//
// One transaction is accepted per clock while in_stall_o is low. A pixel
// enters a stage that holds the line memory read data, passes the compare
// network and lands in the output register, where its result is presented.
// The result of a pixel leaves width+1 transactions after the pixel itself.
// Reset clears the counters, the window and the handshake state; the line
// memories need no clearing since reads are gated by the row. A stall on the
// output holds the middle stage and then stalls the input.
//
module grouped_median_rgb_filter_top #(
  parameter int MAX_WIDTH    = 2048,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Pixel input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [CHANNEL_BITS-1:0]           red_in_i,
  input  logic [CHANNEL_BITS-1:0]           green_in_i,
  input  logic [CHANNEL_BITS-1:0]           blue_in_i,
  input  logic                              is_flush_i,
  // Filtered output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [CHANNEL_BITS-1:0]           red_out_o,
  output logic [CHANNEL_BITS-1:0]           green_out_o,
  output logic [CHANNEL_BITS-1:0]           blue_out_o,
  output logic                              frame_last_o,
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [gmrf_pkg::CFG_ADDR_W-1:0]   cfg_index_i,
  input  logic [gmrf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int PW = 3 * CHANNEL_BITS;
  localparam int RW = gmrf_pkg::ROW_W;

  // Configuration registers.
  logic [gmrf_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [gmrf_pkg::HEIGHT_REG_W-1:0] height_q;
  logic                              restart_cfg;

  // Frame position of the next transaction.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // Decoded frame geometry.
  logic [CW-1:0]                     w_m1;
  logic [gmrf_pkg::HEIGHT_REG_W-1:0] h_eff;
  logic [RW-1:0]                     h_ext;

  // Per-transaction decode at acceptance.
  logic          in_acc;
  logic [CW-1:0] col_cur;
  logic          row_past;
  logic          emit_cur;
  logic          last_cur;
  logic [PW-1:0] pix_cur;

  // Memory stage.
  logic                 s1_valid_q, s1_valid_d;
  logic [CW-1:0]        s1_col_q;
  logic [PW-1:0]        s1_pix_q;
  logic                 s1_top_ok_q;
  logic                 s1_mid_ok_q;
  logic                 s1_emit_q;
  logic                 s1_last_q;
  gmrf_pkg::col_mask_t  s1_mask_q;
  logic                 s1_fwd_q;
  logic [PW-1:0]        fwd_top_q;
  logic [PW-1:0]        fwd_mid_q;
  logic                 s1_adv;
  logic [PW-1:0]        upper_rd;
  logic [PW-1:0]        middle_rd;
  logic [PW-1:0]        top_pix;
  logic [PW-1:0]        mid_pix;

  // Two older window columns: index 0..2 is col-2 (top, mid, bottom),
  // index 3..5 is col-1.
  logic [PW-1:0] win_q [6];

  // Output register.
  logic                    out_valid_q;
  logic                    out_ready;
  logic [CHANNEL_BITS-1:0] red_q, green_q, blue_q;
  logic                    last_q;
  logic [2:0][CHANNEL_BITS-1:0] med;

  // Configuration port; any write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gmrf_pkg::WIDTH_RESET;
      height_q <= gmrf_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (gmrf_pkg::cfg_reg_e'(cfg_index_i))
        gmrf_pkg::CFG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[gmrf_pkg::WIDTH_REG_W-1:0];
        end
        gmrf_pkg::CFG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[gmrf_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign restart_cfg = cfg_we_i;

  // Width is clamped to 1..MAX_WIDTH, height zero counts as one.
  always_comb begin
    if (width_q == '0) begin
      w_m1 = '0;
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(32'(width_q) - 32'd1);
    end
    h_eff = (height_q == '0) ? gmrf_pkg::HEIGHT_REG_W'(1) : height_q;
    h_ext = RW'(h_eff);
  end

  // Handshake between input, memory stage and output register.
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_emit_q || out_ready);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Decode of the accepted transaction from the frame position.
  always_comb begin
    col_cur  = (col_q > w_m1) ? '0 : col_q;
    row_past = row_q >= h_ext;
    emit_cur = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_cur != '0));
    last_cur = emit_cur && (col_cur == '0) && (row_q == h_ext + RW'(1));
    if (is_flush_i || row_past) begin
      pix_cur = '0;
    end else begin
      pix_cur = {blue_in_i, green_in_i, red_in_i};
    end
  end

  // Next frame position.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_cfg) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (last_cur) begin
        col_d = '0;
        row_d = '0;
      end else if (col_cur == w_m1) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_cur + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Memory stage valid.
  always_comb begin
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Memory stage payload; forward the write that lands on the read address.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q             <= col_cur;
      s1_pix_q             <= pix_cur;
      s1_top_ok_q          <= row_q >= RW'(2);
      s1_mid_ok_q          <= row_q >= RW'(1);
      s1_emit_q            <= emit_cur;
      s1_last_q            <= last_cur;
      s1_mask_q.right_zero <= col_cur == '0;
      s1_mask_q.left_zero  <= (col_cur == CW'(1)) || ((col_cur == '0) && (w_m1 == '0));
      s1_fwd_q             <= s1_adv && (s1_col_q == col_cur);
      fwd_top_q            <= mid_pix;
      fwd_mid_q            <= s1_pix_q;
    end
  end

  // Line memories: read on acceptance, written when the pixel leaves.
  gmrf_ram #(
    .DATA_W (PW),
    .DEPTH  (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid_pix),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (upper_rd)
  );

  gmrf_ram #(
    .DATA_W (PW),
    .DEPTH  (MAX_WIDTH)
  ) u_middle_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix_q),
    .re_i    (in_acc),
    .raddr_i (col_cur),
    .rdata_o (middle_rd)
  );

  // Rows above the frame read as zero.
  always_comb begin
    top_pix = '0;
    mid_pix = '0;
    if (s1_top_ok_q) begin
      top_pix = s1_fwd_q ? fwd_top_q : upper_rd;
    end
    if (s1_mid_ok_q) begin
      mid_pix = s1_fwd_q ? fwd_mid_q : middle_rd;
    end
  end

  // Window columns shift as each pixel leaves; the end of a frame or a configuration write clears them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (restart_cfg || (s1_adv && s1_last_q)) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_pix;
      win_q[4] <= mid_pix;
      win_q[5] <= s1_pix_q;
    end
  end

  // One compare network per color channel.
  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [2:0][CHANNEL_BITS-1:0] left_col;
    logic [2:0][CHANNEL_BITS-1:0] center_col;
    logic [2:0][CHANNEL_BITS-1:0] right_col;

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        left_col[r]   = win_q[r][k*CHANNEL_BITS +: CHANNEL_BITS];
        center_col[r] = win_q[r+3][k*CHANNEL_BITS +: CHANNEL_BITS];
      end
      right_col[0] = top_pix[k*CHANNEL_BITS +: CHANNEL_BITS];
      right_col[1] = mid_pix[k*CHANNEL_BITS +: CHANNEL_BITS];
      right_col[2] = s1_pix_q[k*CHANNEL_BITS +: CHANNEL_BITS];
    end

    gmrf_pmed #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_pmed (
      .left_col_i   (left_col),
      .center_col_i (center_col),
      .right_col_i  (right_col),
      .mask_i       (s1_mask_q),
      .med_o        (med[k])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      red_q   <= med[0];
      green_q <= med[1];
      blue_q  <= med[2];
      last_q  <= s1_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign frame_last_o = last_q;

endmodule

@@ tb/tb_grouped_median_rgb_filter_top.sv @@
// ----------------------------------------------------------------------------
// tb_grouped_median_rgb_filter_top
// Self-checking bench for the grouped median RGB filter. A model of the line
// memories and the 3x3 window predicts each filtered pixel; a scoreboard
// compares every output transaction with the oldest prediction. Stimulus is a
// short directed set, a few frames at the extreme geometries, and then random
// frames with random geometry, noise items and random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_grouped_median_rgb_filter_top;

  localparam int MAX_WIDTH     = 2048;
  localparam int ITEM_BUDGET   = 800;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 24;

  // Directed items, packed as {is_flush, red, green, blue}.
  localparam logic [24:0] DIRECTED_FRAME [13] = '{
    {1'b0, 24'h000000}, {1'b0, 24'hFFFFFF}, {1'b0, 24'hAA55FF},
    {1'b0, 24'h55AA00}, {1'b1, 24'hC3C3C3}, {1'b0, 24'hFF0080},
    {1'b0, 24'h01FE7F}, {1'b0, 24'h808080}, {1'b0, 24'hFFFFFF},
    {1'b1, 24'h123456}, {1'b0, 24'hABCDEF}, {1'b1, 24'hFFFFFF},
    {1'b1, 24'h000000}
  };
  localparam logic [24:0] DIRECTED_NARROW [9] = '{
    {1'b0, 24'hFFFFFF}, {1'b1, 24'h5A5A5A}, {1'b1, 24'hFFFFFF},
    {1'b0, 24'h7F80FE}, {1'b0, 24'h3C3C3C}, {1'b1, 24'h000000},
    {1'b0, 24'hA5A5A5}, {1'b1, 24'hFFFFFF}, {1'b1, 24'h000000}
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_last;
  } filtered_px_t;

  // Scoreboard: predicts filtered pixels and checks the output stream.
  class median_scoreboard;
    bit [gmrf_pkg::WIDTH_REG_W-1:0]  width_reg;
    bit [gmrf_pkg::HEIGHT_REG_W-1:0] height_reg;
    bit [23:0]             upper_row [MAX_WIDTH];
    bit [23:0]             middle_row [MAX_WIDTH];
    bit [23:0]             held_cols [6];
    int unsigned           col_pos;
    int unsigned           row_pos;
    filtered_px_t          owed_results [$];
    int unsigned           mismatches;

    function new();
      width_reg  = gmrf_pkg::WIDTH_RESET;
      height_reg = gmrf_pkg::HEIGHT_RESET;
      mismatches = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col_pos = 0;
      row_pos = 0;
      foreach (held_cols[i]) held_cols[i] = '0;
    endfunction

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned active_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Any register write starts a fresh frame.
    function void write_register(gmrf_pkg::cfg_reg_e idx,
                                 logic [gmrf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        gmrf_pkg::CFG_IMAGE_WIDTH:  width_reg = data[gmrf_pkg::WIDTH_REG_W-1:0];
        gmrf_pkg::CFG_IMAGE_HEIGHT: height_reg = data[gmrf_pkg::HEIGHT_REG_W-1:0];
        default: ;
      endcase
      restart_frame();
    endfunction

    function bit [7:0] median3(bit [7:0] a, bit [7:0] b, bit [7:0] c);
      bit [7:0] lo;
      bit [7:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) return lo;
      if (c >= hi) return hi;
      return c;
    endfunction

    // Advances the window by one accepted pixel and queues its result, if any.
    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic flush);
      int unsigned w, h, col, row, cc;
      bit [23:0] px, top, mid;
      bit [23:0] win [9];
      bit [7:0] lane [3];
      bit emit, last;
      filtered_px_t res;
      w = active_width();
      h = active_height();
      col = col_pos;
      row = row_pos;
      if (col >= w) col = 0;
      // Flushes and anything past the last row enter as zero pixels.
      px  = (flush === 1'b1 || row >= h) ? 24'h0 : {r, g, b};
      top = (row >= 2) ? upper_row[col] : 24'h0;
      mid = (row >= 1) ? middle_row[col] : 24'h0;
      upper_row[col]  = mid;
      middle_row[col] = px;
      // Window positions 0..8 row-major; the center column is the one before.
      cc = (col == 0) ? w - 1 : col - 1;
      win[0] = held_cols[0]; win[3] = held_cols[1]; win[6] = held_cols[2];
      win[1] = held_cols[3]; win[4] = held_cols[4]; win[7] = held_cols[5];
      win[2] = top;          win[5] = mid;          win[8] = px;
      if (cc == 0) begin
        win[0] = '0; win[3] = '0; win[6] = '0;
      end
      if (cc == w - 1) begin
        win[2] = '0; win[5] = '0; win[8] = '0;
      end
      held_cols[0] = held_cols[3];
      held_cols[1] = held_cols[4];
      held_cols[2] = held_cols[5];
      held_cols[3] = top;
      held_cols[4] = mid;
      held_cols[5] = px;
      emit = (row >= 2) || (row == 1 && col >= 1);
      last = emit && col == 0 && row == h + 1;
      if (emit) begin
        for (int k = 0; k < 3; k++) begin
          lane[k] = median3(median3(win[0][8*k +: 8], win[5][8*k +: 8], win[6][8*k +: 8]),
                            median3(win[2][8*k +: 8], win[3][8*k +: 8], win[8][8*k +: 8]),
                            median3(win[1][8*k +: 8], win[4][8*k +: 8], win[7][8*k +: 8]));
        end
        res.red        = lane[2];
        res.green      = lane[1];
        res.blue       = lane[0];
        res.frame_last = last;
        owed_results.push_back(res);
      end
      if (last) begin
        restart_frame();
      end else begin
        col++;
        if (col >= w) begin
          col = 0;
          row++;
        end
        col_pos = col;
        row_pos = row;
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 200) $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
      filtered_px_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result %h %h %h last=%b with nothing owed", r, g, b, fl));
        return;
      end
      want = owed_results.pop_front();
      if (r !== want.red)
        report_mismatch($sformatf("red %h, predicted %h", r, want.red));
      if (g !== want.green)
        report_mismatch($sformatf("green %h, predicted %h", g, want.green));
      if (b !== want.blue)
        report_mismatch($sformatf("blue %h, predicted %h", b, want.blue));
      if (fl !== want.frame_last)
        report_mismatch($sformatf("frame_last %b, predicted %b", fl, want.frame_last));
    endtask
  endclass

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      red_in_i     = '0;
  logic [7:0]                      green_in_i   = '0;
  logic [7:0]                      blue_in_i    = '0;
  logic                            is_flush_i   = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i  = 1'b0;
  logic [7:0]                      red_out_o;
  logic [7:0]                      green_out_o;
  logic [7:0]                      blue_out_o;
  logic                            frame_last_o;
  logic                            cfg_we_i     = 1'b0;
  gmrf_pkg::cfg_reg_e              cfg_index_i  = gmrf_pkg::CFG_IMAGE_WIDTH;
  logic [gmrf_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;

  median_scoreboard ledger    = new();
  bit               feed_idle = 1'b1;
  bit               hold_req  = 1'b0;
  int unsigned      fed_items = 0;

  grouped_median_rgb_filter_top #(
    .MAX_WIDTH   (MAX_WIDTH),
    .CHANNEL_BITS(8)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .is_flush_i  (is_flush_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_last_o(frame_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Handshakes are sampled at the falling edge, where all signals are stable.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        ledger.note_pixel(red_in_i, green_in_i, blue_in_i, is_flush_i);
      if (out_valid_o && !out_stall_i)
        ledger.check_result(red_out_o, green_out_o, blue_out_o, frame_last_o);
    end
  end

  function automatic logic [7:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one transaction and returns at the edge that accepts it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic flush);
    int unsigned gap;
    gap = feed_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    is_flush_i <= flush;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    fed_items++;
  endtask

  task automatic send_packed(input logic [24:0] item);
    send_pixel(item[23:16], item[15:8], item[7:0], item[24]);
  endtask

  // Stops the input and waits until every owed result has left the block.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (ledger.owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input gmrf_pkg::cfg_reg_e idx,
                                input logic [gmrf_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    ledger.write_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Well-formed frames with random content and a little noise; the last
  // frame may be cut short when a broken sequence is wanted.
  task automatic feed_frames(input int unsigned count, input bit may_cut);
    int unsigned w, pixels, len;
    w      = ledger.active_width();
    pixels = w * ledger.active_height();
    for (int f = 0; f < count; f++) begin
      len = pixels + w + 1;
      if (may_cut && f == count - 1 && $urandom_range(0, 5) == 0)
        len = $urandom_range(1, len - 1);
      for (int i = 0; i < len; i++) begin
        send_pixel(random_sample(), random_sample(), random_sample(),
                   (i < pixels) ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 7) != 0));
      end
    end
  endtask

  task automatic pick_random_geometry();
    logic [gmrf_pkg::WIDTH_REG_W-1:0]  w;
    logic [gmrf_pkg::HEIGHT_REG_W-1:0] h;
    logic [3:0]                        junk;
    int unsigned                       order;
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = 12'd1;
      8:       w = 12'($urandom_range(9, 24));
      default: w = 12'($urandom_range(2, 8));
    endcase
    h     = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
    junk  = 4'($urandom_range(0, 15));
    order = $urandom_range(0, 3);
    if (order == 3) write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, h);
    if (order != 1) write_register(gmrf_pkg::CFG_IMAGE_WIDTH, {junk, w});
    if (order == 1 || order == 2) write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // Output side: random stalls in stretches, plus one long hold on request.
  initial begin : result_sink
    int unsigned pause, left;
    bit busy;
    busy = 1'b1;
    left = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (left == 0) begin
        busy = ($urandom_range(0, 3) != 0);
        left = $urandom_range(10, 60);
      end
      left--;
      if (hold_req) begin
        hold_req = 1'b0;
        pause = LONG_HOLD;
      end else begin
        pause = busy ? $urandom_range(0, 18) : 0;
      end
      if (pause != 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(negedge clk_i); while (out_valid_o !== 1'b1);
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 3x3 frame with extremes, a flush inside the frame and a pixel
    // during the drain.
    write_register(gmrf_pkg::CFG_IMAGE_WIDTH, 16'h0003);
    write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, 16'h0003);
    foreach (DIRECTED_FRAME[i]) send_packed(DIRECTED_FRAME[i]);
    drain_block();

    // Width one, height zero: two back-to-back frames without a write between.
    write_register(gmrf_pkg::CFG_IMAGE_WIDTH, 16'hF001);
    write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, 16'h0000);
    for (int i = 0; i < 6; i++) send_packed(DIRECTED_NARROW[i]);
    drain_block();

    // Width zero is taken as one.
    write_register(gmrf_pkg::CFG_IMAGE_WIDTH, 16'h0000);
    for (int i = 6; i < 9; i++) send_packed(DIRECTED_NARROW[i]);
    drain_block();

    // Width above the line depth is clamped; the first row of such a frame
    // gives no result, and a write cuts the frame short.
    feed_idle = 1'b0;
    write_register(gmrf_pkg::CFG_IMAGE_WIDTH, 16'hFFFF);
    write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, 16'h0002);
    for (int i = 0; i < 40; i++) send_pixel(random_sample(), random_sample(), random_sample(), 1'b0);
    drain_block();

    // Tallest frame, only its first rows.
    feed_idle = 1'b1;
    write_register(gmrf_pkg::CFG_IMAGE_WIDTH, 16'hF002);
    write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 60; i++)
      send_pixel(random_sample(), random_sample(), random_sample(), $urandom_range(0, 15) == 0);
    drain_block();

    // Back pressure: the sink holds off while pixels keep coming.
    feed_idle = 1'b0;
    write_register(gmrf_pkg::CFG_IMAGE_WIDTH, 16'h0008);
    write_register(gmrf_pkg::CFG_IMAGE_HEIGHT, 16'h0006);
    hold_req = 1'b1;
    feed_frames(1, 1'b0);
    drain_block();

    // Random geometry and content.
    while (fed_items < ITEM_BUDGET) begin
      feed_idle = ($urandom_range(0, 3) != 0);
      pick_random_geometry();
      feed_frames($urandom_range(1, 3), 1'b1);
      drain_block();
    end

    if (ledger.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/gmrf_pkg.sv
hdl/gmrf_ram.sv
hdl/gmrf_pmed.sv
hdl/grouped_median_rgb_filter_top.sv
tb/tb_grouped_median_rgb_filter_top.sv
